### sv/bbc_pkg.sv
package bbc_pkg;

  localparam int SLOT_COUNT_DEF = 8;

  localparam int OP_W    = 2;
  localparam int DEV_W   = 4;
  localparam int BLK_W   = 16;
  localparam int MODE_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;
  localparam int STAMP_W = 16;

  localparam logic [OP_W-1:0] OP_READ = 2'd0;
  localparam logic [OP_W-1:0] OP_REL  = 2'd1;
  localparam logic [OP_W-1:0] OP_ZBUF = 2'd2;
  localparam logic [OP_W-1:0] OP_SYNC = 2'd3;

  localparam logic [MODE_W-1:0] REW_FETCH = 2'd0;
  localparam logic [MODE_W-1:0] REW_ZERO  = 2'd2;

  localparam logic [MODE_W-1:0] DM_CLEAN = 2'd0;
  localparam logic [MODE_W-1:0] DM_NOW   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_GRANT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ZERO  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DONE  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BUSY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOFREE = 2'd2;

  // which slot index the datapath works on this cycle
  typedef enum logic [1:0] {SEL_HIT, SEL_VICT, SEL_REL, SEL_SCAN} sel_t;

  // where the reported slot number comes from
  typedef enum logic [1:0] {SLOT_SEL, SLOT_ZERO, SLOT_REQ} slot_src_t;

  typedef struct packed {
    logic              load;
    logic              scan_clr;
    logic              scan_step;
    sel_t              sel;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic [STAT_W-1:0] status;
    logic              last;
    slot_src_t         slot_src;
    logic              grant;
    logic              clr_dirty;
    logic              rename;
    logic              invalidate;
    logic              release_slot;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [MODE_W-1:0] rew;
    logic [MODE_W-1:0] dm;
    logic              rel_ok;
    logic              scan_last;
    logic              hit_found;
    logic              hit_busy;
    logic              vict_found;
    logic              sel_wb;
    logic              scan_wb;
    logic              can_emit;
  } stat_t;

endpackage

### sv/bbc_dp.sv
module bbc_dp #(
  parameter int SLOT_COUNT = bbc_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bbc_pkg::OP_W-1:0]    in_operation,
  input  logic [bbc_pkg::DEV_W-1:0]   in_device,
  input  logic [bbc_pkg::BLK_W-1:0]   in_block,
  input  logic [bbc_pkg::MODE_W-1:0]  in_rewrite_mode,
  input  logic [bbc_pkg::SLOT_W-1:0]  in_slot,
  input  logic [bbc_pkg::MODE_W-1:0]  in_dirty_mode,
  input  bbc_pkg::cmd_t               cmd,
  output bbc_pkg::stat_t              stat,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [bbc_pkg::KIND_W-1:0]  out_kind,
  output logic [bbc_pkg::SLOT_W-1:0]  out_slot,
  output logic [bbc_pkg::DEV_W-1:0]   out_device,
  output logic [bbc_pkg::BLK_W-1:0]   out_block,
  output logic [bbc_pkg::STAT_W-1:0]  out_status,
  output logic                        out_last
);
  import bbc_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  // captured request
  logic [OP_W-1:0]   op;
  logic [DEV_W-1:0]  dev;
  logic [BLK_W-1:0]  blk;
  logic [MODE_W-1:0] rew;
  logic [SLOT_W-1:0] rslot;
  logic [MODE_W-1:0] dm;

  // tag store
  logic [SLOT_COUNT-1:0] valid;
  logic [SLOT_COUNT-1:0] busy;
  logic [SLOT_COUNT-1:0] dirty;
  logic [DEV_W-1:0]      tag_dev [SLOT_COUNT];
  logic [BLK_W-1:0]      tag_blk [SLOT_COUNT];
  logic [STAMP_W-1:0]    age     [SLOT_COUNT];
  logic [STAMP_W-1:0]    counter;

  // scan state
  logic [IW-1:0]      cnt;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      vict_idx;
  logic               hit_found;
  logic               vict_found;
  logic [STAMP_W-1:0] best_age;

  logic [IW-1:0]      sel_idx;
  logic [IW-1:0]      rel_idx;
  logic               scan_match;
  logic               scan_take;
  logic [STAMP_W-1:0] age_now;
  logic [STAMP_W-1:0] stamp_next;
  logic               has_tag;
  logic [SLOT_W-1:0]  slot_pick;

  assign rel_idx    = IW'(rslot);
  assign age_now    = counter - age[cnt];
  assign stamp_next = counter + 16'd1;
  assign scan_match = valid[cnt] && (tag_dev[cnt] == dev) && (tag_blk[cnt] == blk);
  assign scan_take  = !busy[cnt] && (age_now >= best_age);

  always_comb begin
    case (cmd.sel)
      SEL_HIT:  sel_idx = hit_idx;
      SEL_VICT: sel_idx = vict_idx;
      SEL_REL:  sel_idx = rel_idx;
      SEL_SCAN: sel_idx = cnt;
      default:  sel_idx = cnt;
    endcase
  end

  always_comb begin
    case (cmd.slot_src)
      SLOT_SEL:  slot_pick = SLOT_W'(sel_idx);
      SLOT_ZERO: slot_pick = '0;
      SLOT_REQ:  slot_pick = rslot;
      default:   slot_pick = '0;
    endcase
  end

  assign has_tag = (cmd.kind != KIND_DONE) && valid[sel_idx];

  always_comb begin
    stat.op         = op;
    stat.rew        = rew;
    stat.dm         = dm;
    stat.rel_ok     = int'(rslot) < SLOT_COUNT;
    stat.scan_last  = (cnt == LAST_IDX);
    stat.hit_found  = hit_found;
    stat.hit_busy   = busy[hit_idx];
    stat.vict_found = vict_found;
    stat.sel_wb     = dirty[sel_idx] && valid[sel_idx];
    stat.scan_wb    = valid[cnt] && dirty[cnt];
    stat.can_emit   = !out_valid || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      busy       <= '0;
      dirty      <= '0;
      counter    <= '0;
      cnt        <= '0;
      hit_found  <= 1'b0;
      vict_found <= 1'b0;
      best_age   <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        age[i] <= '0;
      end
    end else begin
      if (cmd.scan_clr) begin
        cnt        <= '0;
        hit_found  <= 1'b0;
        vict_found <= 1'b0;
        best_age   <= '0;
      end
      if (cmd.scan_step) begin
        cnt <= cnt + 1'b1;
        if (scan_match && !hit_found) begin
          hit_found <= 1'b1;
        end
        if (scan_take) begin
          vict_found <= 1'b1;
          best_age   <= age_now;
        end
      end
      if (cmd.grant) begin
        busy[sel_idx] <= 1'b1;
        counter       <= stamp_next;
        age[sel_idx]  <= stamp_next;
      end
      if (cmd.release_slot) begin
        busy[sel_idx] <= 1'b0;
        if (dm != DM_CLEAN) begin
          dirty[sel_idx] <= 1'b1;
        end
      end
      if (cmd.clr_dirty) begin
        dirty[sel_idx] <= 1'b0;
      end
      if (cmd.rename) begin
        valid[sel_idx] <= 1'b1;
      end
      if (cmd.invalidate) begin
        valid[sel_idx] <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= in_operation;
      dev   <= in_device;
      blk   <= in_block;
      rew   <= in_rewrite_mode;
      rslot <= in_slot;
      dm    <= in_dirty_mode;
    end
    if (cmd.scan_step) begin
      if (scan_match && !hit_found) begin
        hit_idx <= cnt;
      end
      if (scan_take) begin
        vict_idx <= cnt;
      end
    end
    if (cmd.rename) begin
      tag_dev[sel_idx] <= dev;
      tag_blk[sel_idx] <= blk;
    end
    if (cmd.emit) begin
      out_kind   <= cmd.kind;
      out_slot   <= slot_pick;
      out_device <= has_tag ? tag_dev[sel_idx] : '0;
      out_block  <= has_tag ? tag_blk[sel_idx] : '0;
      out_status <= cmd.status;
      out_last   <= cmd.last;
    end
  end

endmodule

### sv/bbc_ctrl.sv
module bbc_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [bbc_pkg::OP_W-1:0] in_op,
  output logic                     in_ready,
  input  bbc_pkg::stat_t           stat,
  output bbc_pkg::cmd_t            cmd
);
  import bbc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_WB, S_FILL, S_GRANT, S_ZB_ZERO, S_ZB_GRANT,
    S_REL_UPD, S_REL_WB, S_REL_DONE, S_SYNC_SCAN, S_SYNC_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.sel      = SEL_VICT;
    cmd.slot_src = SLOT_SEL;
    state_next   = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          case (in_op)
            OP_REL:  state_next = S_REL_UPD;
            OP_SYNC: state_next = S_SYNC_SCAN;
            default: state_next = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.can_emit) begin
          if (stat.op == OP_READ && stat.hit_found) begin
            cmd.sel  = SEL_HIT;
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            if (stat.hit_busy) begin
              cmd.kind   = KIND_DONE;
              cmd.status = ST_BUSY;
            end else begin
              cmd.kind  = KIND_GRANT;
              cmd.grant = 1'b1;
            end
            state_next = S_IDLE;
          end else if (!stat.vict_found) begin
            cmd.emit     = 1'b1;
            cmd.kind     = KIND_DONE;
            cmd.status   = ST_NOFREE;
            cmd.slot_src = SLOT_ZERO;
            cmd.last     = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_WB;
          end
        end
      end
      S_WB: begin
        // write-back report uses the old tag; rename lands on the same edge
        if (!stat.sel_wb || stat.can_emit) begin
          cmd.clr_dirty = 1'b1;
          cmd.emit      = stat.sel_wb;
          cmd.kind      = KIND_WRITE;
          if (stat.op == OP_READ) begin
            cmd.rename = 1'b1;
            state_next = S_FILL;
          end else begin
            cmd.invalidate = 1'b1;
            state_next     = S_ZB_ZERO;
          end
        end
      end
      S_FILL: begin
        if (stat.rew == REW_FETCH || stat.rew == REW_ZERO) begin
          if (stat.can_emit) begin
            cmd.emit   = 1'b1;
            cmd.kind   = (stat.rew == REW_FETCH) ? KIND_READ : KIND_ZERO;
            state_next = S_GRANT;
          end
        end else begin
          state_next = S_GRANT;
        end
      end
      S_GRANT: begin
        if (stat.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_GRANT;
          cmd.grant  = 1'b1;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ZB_ZERO: begin
        if (stat.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_ZERO;
          state_next = S_ZB_GRANT;
        end
      end
      S_ZB_GRANT: begin
        if (stat.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_GRANT;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REL_UPD: begin
        cmd.sel          = SEL_REL;
        cmd.release_slot = stat.rel_ok;
        state_next = (stat.rel_ok && stat.dm == DM_NOW) ? S_REL_WB : S_REL_DONE;
      end
      S_REL_WB: begin
        cmd.sel = SEL_REL;
        if (!stat.sel_wb || stat.can_emit) begin
          cmd.clr_dirty = 1'b1;
          cmd.emit      = stat.sel_wb;
          cmd.kind      = KIND_WRITE;
          state_next    = S_REL_DONE;
        end
      end
      S_REL_DONE: begin
        if (stat.can_emit) begin
          cmd.emit     = 1'b1;
          cmd.kind     = KIND_DONE;
          cmd.slot_src = SLOT_REQ;
          cmd.last     = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SYNC_SCAN: begin
        cmd.sel = SEL_SCAN;
        if (!stat.scan_wb || stat.can_emit) begin
          cmd.scan_step = 1'b1;
          cmd.emit      = stat.scan_wb;
          cmd.kind      = KIND_WRITE;
          if (stat.scan_last) begin
            state_next = S_SYNC_DONE;
          end
        end
      end
      S_SYNC_DONE: begin
        if (stat.can_emit) begin
          cmd.emit     = 1'b1;
          cmd.kind     = KIND_DONE;
          cmd.slot_src = SLOT_ZERO;
          cmd.last     = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/block_buffer_cache_lru_top.sv
// Channel  Dir  Signals                          Contents
// s_       in   s_tvalid s_tready s_tdata s_tuser  request: operation + block/slot fields
// m_       out  m_tvalid m_tready m_tdata m_tuser  result: kind + slot/tag/status, m_tlast
//
// Read and zero-buffer walk the tag store one slot per cycle, then, unless a read hits,
// write back, fill and grant. Release updates the slot, may write it back and reports
// done; sync walks every slot, reporting each valid dirty one. The slot walk sets the rate.
// Reset (rst, synchronous) empties every slot and zeroes all age stamps and the counter.
// Results leave through one output register; each further result waits while m_tready is
// low, and a new request is taken once the final result of the last one is registered.
module block_buffer_cache_lru_top #(
  parameter int SLOT_COUNT = bbc_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // device[3:0], block[19:4], rewrite_mode[21:20], slot[24:22], dirty_mode[26:25]
  input  logic [31:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_slot[2:0], out_device[6:3], out_block[22:7], status[24:23]
  output logic [31:0] m_tdata,
  // kind[2:0]
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);
  import bbc_pkg::*;

  logic [DEV_W-1:0]  req_device;
  logic [BLK_W-1:0]  req_block;
  logic [MODE_W-1:0] req_rewrite;
  logic [SLOT_W-1:0] req_slot;
  logic [MODE_W-1:0] req_dirty;

  logic [SLOT_W-1:0] res_slot;
  logic [DEV_W-1:0]  res_device;
  logic [BLK_W-1:0]  res_block;
  logic [STAT_W-1:0] res_status;

  cmd_t  cmd;
  stat_t stat;

  // unpack the request
  assign req_device  = s_tdata[3:0];
  assign req_block   = s_tdata[19:4];
  assign req_rewrite = s_tdata[21:20];
  assign req_slot    = s_tdata[24:22];
  assign req_dirty   = s_tdata[26:25];

  // pack the result, zero pad to a whole word
  assign m_tdata = {7'd0, res_status, res_block, res_device, res_slot};

  bbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bbc_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .in_operation    (s_tuser),
    .in_device       (req_device),
    .in_block        (req_block),
    .in_rewrite_mode (req_rewrite),
    .in_slot         (req_slot),
    .in_dirty_mode   (req_dirty),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_kind        (m_tuser),
    .out_slot        (res_slot),
    .out_device      (res_device),
    .out_block       (res_block),
    .out_status      (res_status),
    .out_last        (m_tlast)
  );

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.can_emit)
    else $error("result register overwritten");

  // an accepted transaction leaves the controller busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous one in progress");

  // the final result of a transaction returns the controller to idle
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.last |=> s_tready)
    else $error("controller not idle after final result");

  // a stamp and busy mark only come with a grant result
  a_grant_reported: assert property (@(posedge clk) disable iff (rst)
    cmd.grant |-> cmd.emit && cmd.kind == KIND_GRANT && cmd.last)
    else $error("slot granted without grant result");

endmodule

### dv/tb_block_buffer_cache_lru_top.sv
module tb_block_buffer_cache_lru_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int POOL_N = 12;   // more tags than slots, so the random part keeps evicting

  // rewrite and dirty codes the package leaves unnamed
  localparam logic [MODE_W-1:0] REW_NAME     = 2'd1;
  localparam logic [MODE_W-1:0] REW_NAME_ALT = 2'd3;
  localparam logic [MODE_W-1:0] DM_MARK      = 2'd1;
  localparam logic [MODE_W-1:0] DM_MARK_ALT  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [STAT_W-1:0] status;
    logic              last;
  } result_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [MODE_W-1:0] rew;
    logic [SLOT_W-1:0] slot;
    logic [MODE_W-1:0] dm;
    bit                typed;   // want holds the one result, written by hand
    result_t           want;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  block_buffer_cache_lru_top #(.SLOT_COUNT(SLOTS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Tag store shadow: our own copy of the cache state, advanced once per
  // accepted request transaction.
  // ---------------------------------------------------------------------------
  logic              tag_ok    [SLOTS];
  logic [DEV_W-1:0]  tag_dev   [SLOTS];
  logic [BLK_W-1:0]  tag_blk   [SLOTS];
  logic              slot_held [SLOTS];
  logic              slot_mod  [SLOTS];
  logic [STAMP_W-1:0] age_of   [SLOTS];
  logic [STAMP_W-1:0] stamp_now;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tag_ok[i] = 1'b0; tag_dev[i] = '0; tag_blk[i] = '0;
      slot_held[i] = 1'b0; slot_mod[i] = 1'b0; age_of[i] = '0;
    end
    stamp_now = '0;
  end

  result_t step_results[$];   // results of the request being modeled
  result_t awaited[$];        // results the block still owes, oldest first
  int      mismatches = 0;

  // Device and block are only reported for a valid slot, and never on done.
  function automatic void note_result(logic [KIND_W-1:0] kind, int s,
                                      logic [STAT_W-1:0] status);
    result_t r;
    bit      has_tag;
    has_tag  = (kind != KIND_DONE) && s < SLOTS && tag_ok[s];
    r.kind   = kind;
    r.slot   = s[SLOT_W-1:0];
    r.dev    = has_tag ? tag_dev[s] : '0;
    r.blk    = has_tag ? tag_blk[s] : '0;
    r.status = status;
    r.last   = 1'b0;
    step_results.push_back(r);
  endfunction

  // LRU victim: largest modular age among idle slots, later slot wins a tie.
  function automatic int lru_victim();
    int               best = -1;
    logic [STAMP_W-1:0] best_age = '0;
    logic [STAMP_W-1:0] a;
    for (int i = 0; i < SLOTS; i++) begin
      a = stamp_now - age_of[i];
      if (!slot_held[i] && a >= best_age) begin
        best = i;
        best_age = a;
      end
    end
    return best;
  endfunction

  // A dirty slot with no valid tag is dropped silently.
  function automatic void write_back(int s);
    if (slot_mod[s] && tag_ok[s])
      note_result(KIND_WRITE, s, ST_OK);
    slot_mod[s] = 1'b0;
  endfunction

  function automatic void grant_and_stamp(int s);
    slot_held[s] = 1'b1;
    stamp_now    = stamp_now + 1'b1;
    age_of[s]    = stamp_now;
    note_result(KIND_GRANT, s, ST_OK);
  endfunction

  function automatic void cache_step(request_t rq);
    int hit = -1;
    int v;
    step_results.delete();
    case (rq.op)
      OP_READ: begin
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && tag_ok[i] && tag_dev[i] == rq.dev && tag_blk[i] == rq.blk)
            hit = i;
        if (hit >= 0) begin
          if (slot_held[hit]) note_result(KIND_DONE, hit, ST_BUSY);
          else grant_and_stamp(hit);
        end else begin
          v = lru_victim();
          if (v < 0) begin
            note_result(KIND_DONE, 0, ST_NOFREE);
          end else begin
            write_back(v);
            tag_ok[v]  = 1'b1;
            tag_dev[v] = rq.dev;
            tag_blk[v] = rq.blk;
            if (rq.rew == REW_FETCH) note_result(KIND_READ, v, ST_OK);
            else if (rq.rew == REW_ZERO) note_result(KIND_ZERO, v, ST_OK);
            grant_and_stamp(v);
          end
        end
      end
      OP_REL: begin
        if (int'(rq.slot) < SLOTS) begin
          if (rq.dm != DM_CLEAN) slot_mod[rq.slot] = 1'b1;
          slot_held[rq.slot] = 1'b0;
          if (rq.dm == DM_NOW) write_back(int'(rq.slot));
        end
        note_result(KIND_DONE, int'(rq.slot), ST_OK);
      end
      OP_ZBUF: begin
        v = lru_victim();
        if (v < 0) begin
          note_result(KIND_DONE, 0, ST_NOFREE);
        end else begin
          write_back(v);
          tag_ok[v] = 1'b0;
          note_result(KIND_ZERO, v, ST_OK);
          note_result(KIND_GRANT, v, ST_OK);
        end
      end
      default: begin
        // sync: write every valid dirty slot, dirty bits stay set
        for (int i = 0; i < SLOTS; i++)
          if (tag_ok[i] && slot_mod[i]) note_result(KIND_WRITE, i, ST_OK);
        note_result(KIND_DONE, 0, ST_OK);
      end
    endcase
    step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: offer one transaction, model it once accepted, then either
  // keep tvalid up for the rest of the burst or drop it for a random gap.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  bit random_phase = 1'b0;

  task automatic offer(input request_t rq);
    s_tuser  <= rq.op;
    s_tdata  <= {5'b0, rq.dm, rq.slot, rq.rew, rq.blk, rq.dev};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    cache_step(rq);
    if (rq.typed) awaited.push_back(rq.want);
    else foreach (step_results[i]) awaited.push_back(step_results[i]);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long gapless burst
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  request_t directed[$];

  function automatic void add_row(logic [OP_W-1:0] op, logic [DEV_W-1:0] dev,
                                  logic [BLK_W-1:0] blk, logic [MODE_W-1:0] rew,
                                  logic [SLOT_W-1:0] slot, logic [MODE_W-1:0] dm);
    request_t rq;
    rq.op = op; rq.dev = dev; rq.blk = blk; rq.rew = rew; rq.slot = slot; rq.dm = dm;
    rq.typed = 1'b0;
    rq.want = '0;
    directed.push_back(rq);
  endfunction

  // Single done result, so device and block are zero and last is set.
  function automatic void add_typed(logic [OP_W-1:0] op, logic [DEV_W-1:0] dev,
                                    logic [BLK_W-1:0] blk, logic [SLOT_W-1:0] slot,
                                    logic [MODE_W-1:0] dm, logic [SLOT_W-1:0] out_slot,
                                    logic [STAT_W-1:0] status);
    add_row(op, dev, blk, REW_FETCH, slot, dm);
    directed[$].typed       = 1'b1;
    directed[$].want.kind   = KIND_DONE;
    directed[$].want.slot   = out_slot;
    directed[$].want.status = status;
    directed[$].want.last   = 1'b1;
  endfunction

  initial begin
    request_t          rq;
    logic [DEV_W-1:0]  pool_dev [POOL_N];
    logic [BLK_W-1:0]  pool_blk [POOL_N];
    int                held[$];
    int                pick;

    // Directed part. Slots fill from the top because all ages tie at reset.
    add_typed(OP_SYNC, 4'd0, 16'h0000, 3'd0, DM_CLEAN, 3'd0, ST_OK);     // empty cache
    add_row(OP_READ, 4'd15, 16'hFFFF, REW_FETCH, 3'd0, DM_CLEAN);          // max tag, fetch
    add_typed(OP_READ, 4'd15, 16'hFFFF, 3'd0, DM_CLEAN, 3'd7, ST_BUSY);  // same block again
    add_row(OP_READ, 4'd0, 16'h0000, REW_ZERO, 3'd0, DM_CLEAN);            // min tag, zero fill
    add_row(OP_READ, 4'd5, 16'h1234, REW_NAME, 3'd0, DM_CLEAN);
    add_row(OP_READ, 4'd15, 16'h0000, REW_NAME_ALT, 3'd0, DM_CLEAN);
    add_row(OP_READ, 4'd0, 16'hFFFF, REW_FETCH, 3'd0, DM_CLEAN);
    add_row(OP_READ, 4'd10, 16'h5555, REW_ZERO, 3'd0, DM_CLEAN);
    add_row(OP_READ, 4'd5, 16'hAAAA, REW_NAME, 3'd0, DM_CLEAN);
    add_row(OP_READ, 4'd3, 16'h8001, REW_FETCH, 3'd0, DM_CLEAN);           // last free slot
    add_typed(OP_READ, 4'd9, 16'h0009, 3'd0, DM_CLEAN, 3'd0, ST_NOFREE); // every slot held
    add_typed(OP_ZBUF, 4'd0, 16'h0000, 3'd0, DM_CLEAN, 3'd0, ST_NOFREE);
    add_typed(OP_REL, 4'd0, 16'h0000, 3'd7, DM_MARK, 3'd7, ST_OK);
    add_row(OP_REL, 4'd0, 16'h0000, REW_FETCH, 3'd0, DM_NOW);              // write out now
    add_row(OP_REL, 4'd0, 16'h0000, REW_FETCH, 3'd3, DM_MARK_ALT);
    add_row(OP_SYNC, 4'd0, 16'h0000, REW_FETCH, 3'd0, DM_CLEAN);           // dirty bits stay
    add_row(OP_READ, 4'd12, 16'h0100, REW_FETCH, 3'd0, DM_CLEAN);          // dirty victim
    add_typed(OP_REL, 4'd0, 16'h0000, 3'd5, DM_CLEAN, 3'd5, ST_OK);
    add_row(OP_ZBUF, 4'd0, 16'h0000, REW_FETCH, 3'd0, DM_CLEAN);           // invalidates a slot
    add_typed(OP_REL, 4'd0, 16'h0000, 3'd5, DM_MARK, 3'd5, ST_OK);       // dirty but invalid
    add_row(OP_SYNC, 4'd0, 16'h0000, REW_FETCH, 3'd0, DM_CLEAN);           // skips it
    add_row(OP_READ, 4'd1, 16'h0002, REW_FETCH, 3'd0, DM_CLEAN);           // evicts it, no write
    add_row(OP_REL, 4'd0, 16'h0000, REW_FETCH, 3'd2, DM_NOW);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) offer(directed[i]);

    // Random part: mostly reads of a small tag pool and releases of held
    // slots, so hits, evictions and write-backs all keep happening.
    random_phase <= 1'b1;
    foreach (pool_dev[i]) begin
      pool_dev[i] = DEV_W'($urandom);
      pool_blk[i] = BLK_W'($urandom);
    end
    pool_dev[0] = '0;
    pool_blk[0] = '0;
    pool_dev[1] = '1;
    pool_blk[1] = '1;

    repeat (87) begin
      rq.typed = 1'b0;
      rq.want  = '0;
      rq.dev   = DEV_W'($urandom);
      rq.blk   = BLK_W'($urandom);
      rq.rew   = MODE_W'($urandom_range(0, 3));
      rq.slot  = SLOT_W'($urandom_range(0, SLOTS - 1));
      rq.dm    = MODE_W'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        rq.op = OP_READ;
        if ($urandom_range(0, 4) != 0) begin
          pick = $urandom_range(0, POOL_N - 1);
          rq.dev = pool_dev[pick];
          rq.blk = pool_blk[pick];
        end
      end else if (pick < 80) begin
        rq.op = OP_REL;
        held.delete();
        for (int i = 0; i < SLOTS; i++) if (slot_held[i]) held.push_back(i);
        if (held.size() != 0 && $urandom_range(0, 6) != 0)
          rq.slot = SLOT_W'(held[$urandom_range(0, held.size() - 1)]);
      end else if (pick < 90) begin
        rq.op = OP_ZBUF;
      end else begin
        rq.op = OP_SYNC;
      end
      offer(rq);
    end
    s_tvalid <= 1'b0;

    while (awaited.size() != 0) @(posedge clk);
    // room for a stray result to show up
    repeat (4 * SLOTS + 20) @(posedge clk);

    if (mismatches == 0 && awaited.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: tready pattern is picked by bits 8:7 of a free-running counter; once in
  // the random part it stays low for a long stretch so the block backs up into s_tready.
  // ---------------------------------------------------------------------------
  logic [15:0] ready_cyc = '0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    ready_cyc <= ready_cyc + 1'b1;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (random_phase && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      case (ready_cyc[8:7])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= 1'($urandom_range(0, 1));
        2'd2: m_tready <= (ready_cyc[1:0] == 2'd0);
        default: m_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Compare every result transaction against the oldest awaited one.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind   = m_tuser;
      got.slot   = m_tdata[2:0];
      got.dev    = m_tdata[6:3];
      got.blk    = m_tdata[22:7];
      got.status = m_tdata[24:23];
      got.last   = m_tlast;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d slot %0d dev %0d blk %h status %0d last %0d",
                   got.kind, got.slot, got.dev, got.blk, got.status, got.last);
      end else begin
        want = awaited.pop_front();
        if (got.kind !== want.kind || got.slot !== want.slot || got.dev !== want.dev ||
            got.blk !== want.blk || got.status !== want.status || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: kind %0d slot %0d dev %0d blk %h status %0d last %0d",
                     want.kind, want.slot, want.dev, want.blk, want.status, want.last);
            $display("         got: kind %0d slot %0d dev %0d blk %h status %0d last %0d",
                     got.kind, got.slot, got.dev, got.blk, got.status, got.last);
          end
        end
      end
    end
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
